[rtl/core/i2cm_pkg.sv]
// ---------------------------------------------------------------------------
// i2cm_pkg
// Shared types, codes and helpers for the 16-bit register I2C master.
// ---------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned DEV_W   = 7;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 3;

    localparam logic [DEV_W-1:0] DEV_ADDR_RST = 7'd86;

    // command codes carried on the input tuser
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // byte slot numbers in the transfer sequence
    localparam logic [IDX_W-1:0] BN_DEV_W  = 3'd0;
    localparam logic [IDX_W-1:0] BN_REG_LO = 3'd1;
    localparam logic [IDX_W-1:0] BN_REG_HI = 3'd2;
    localparam logic [IDX_W-1:0] BN_DAT_LO = 3'd3;
    localparam logic [IDX_W-1:0] BN_DAT_HI = 3'd4;
    localparam logic [IDX_W-1:0] BN_DEV_R  = 3'd5;
    localparam logic [IDX_W-1:0] BN_RD_LO  = 3'd6;
    localparam logic [IDX_W-1:0] BN_RD_HI  = 3'd7;

    localparam logic [IDX_W-1:0] BIT_MSB = 3'd7;
    localparam logic [IDX_W-1:0] BIT_LSB = 3'd0;

    // register map (word index)
    localparam logic REG_DEVICE_ADDR = 1'b0;

    typedef enum logic [20:0] {
        PH_IDLE    = 21'h000001,
        PH_START0  = 21'h000002,
        PH_START1  = 21'h000004,
        PH_START2  = 21'h000008,
        PH_START3  = 21'h000010,
        PH_WB_SDA  = 21'h000020,
        PH_WB_SCLH = 21'h000040,
        PH_WB_SCLL = 21'h000080,
        PH_WA_SDA  = 21'h000100,
        PH_WA_SCLH = 21'h000200,
        PH_WA_SCLL = 21'h000400,
        PH_RB_SET  = 21'h000800,
        PH_RB_SCLH = 21'h001000,
        PH_RB_SCLL = 21'h002000,
        PH_RA_SDA  = 21'h004000,
        PH_RA_SCLH = 21'h008000,
        PH_RA_SCLL = 21'h010000,
        PH_RA_REL  = 21'h020000,
        PH_SP_SDAL = 21'h040000,
        PH_SP_SCLH = 21'h080000,
        PH_SP_SDAH = 21'h100000
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [IDX_W-1:0]    byte_num;
        logic [IDX_W-1:0]    bit_num;
        logic [BYTE_W-1:0]   shift;
        logic [BYTE_W-1:0]   low_store;
        logic [WORD_W-1:0]   read_result;
        logic [WORD_W-1:0]   held_addr;
        logic [WORD_W-1:0]   held_val;
        logic                is_read;
        logic                all_acked;
        logic                scl;
        logic                sda;
    } t_state;

    typedef struct packed {
        logic [1:0]          action;
        logic [WORD_W-1:0]   reg_addr;
        logic [WORD_W-1:0]   wr_val;
        logic                sda_in;
    } t_tick;

    typedef struct packed {
        logic done;
        logic ok;
    } t_flags;

    function automatic logic [BYTE_W-1:0] byte_to_send(
        input logic [DEV_W-1:0]  dev,
        input logic [WORD_W-1:0] addr,
        input logic [WORD_W-1:0] val,
        input logic [IDX_W-1:0]  n
    );
        logic [BYTE_W-1:0] b;
        b = {dev, 1'b0};
        unique case (n)
            BN_DEV_W:  b = {dev, 1'b0};
            BN_REG_LO: b = addr[7:0];
            BN_REG_HI: b = addr[15:8];
            BN_DAT_LO: b = val[7:0];
            BN_DAT_HI: b = val[15:8];
            default:   b = {dev, 1'b1};
        endcase
        return b;
    endfunction

endpackage

[rtl/core/i2cm_step.sv]
// ---------------------------------------------------------------------------
// i2cm_step
// One bus step: next sequencer state and stop flags from state and tick.
// ---------------------------------------------------------------------------
module i2cm_step (
    input  i2cm_pkg::t_state                  i_state,
    input  i2cm_pkg::t_tick                   i_tick,
    input  logic [i2cm_pkg::DEV_W-1:0]        i_dev_addr,
    output i2cm_pkg::t_state                  o_state,
    output i2cm_pkg::t_flags                  o_flags
);

    i2cm_pkg::t_state s;
    logic             w_idle;
    logic             w_cmd;

    // any non-active code behaves as idle
    always_comb begin
        w_idle = 1'b1;
        unique case (i_state.phase)
            i2cm_pkg::PH_START0, i2cm_pkg::PH_START1, i2cm_pkg::PH_START2,
            i2cm_pkg::PH_START3, i2cm_pkg::PH_WB_SDA, i2cm_pkg::PH_WB_SCLH,
            i2cm_pkg::PH_WB_SCLL, i2cm_pkg::PH_WA_SDA, i2cm_pkg::PH_WA_SCLH,
            i2cm_pkg::PH_WA_SCLL, i2cm_pkg::PH_RB_SET, i2cm_pkg::PH_RB_SCLH,
            i2cm_pkg::PH_RB_SCLL, i2cm_pkg::PH_RA_SDA, i2cm_pkg::PH_RA_SCLH,
            i2cm_pkg::PH_RA_SCLL, i2cm_pkg::PH_RA_REL, i2cm_pkg::PH_SP_SDAL,
            i2cm_pkg::PH_SP_SCLH, i2cm_pkg::PH_SP_SDAH: w_idle = 1'b0;
            default: w_idle = 1'b1;
        endcase
    end

    assign w_cmd = w_idle && (i_tick.action == i2cm_pkg::ACT_WRITE ||
                              i_tick.action == i2cm_pkg::ACT_READ);

    always_comb begin
        s       = i_state;
        o_flags = '0;
        if (w_idle) begin
            s.phase = i2cm_pkg::PH_IDLE;
        end
        if (w_cmd) begin
            s.held_addr = i_tick.reg_addr;
            s.held_val  = i_tick.wr_val;
            s.is_read   = (i_tick.action == i2cm_pkg::ACT_READ);
            s.all_acked = 1'b1;
            s.byte_num  = i2cm_pkg::BN_DEV_W;
            s.bit_num   = i2cm_pkg::BIT_MSB;
            s.phase     = i2cm_pkg::PH_START0;
        end

        unique case (s.phase)
            i2cm_pkg::PH_START0: begin
                s.sda   = 1'b1;
                s.phase = i2cm_pkg::PH_START1;
            end
            i2cm_pkg::PH_START1: begin
                s.scl   = 1'b1;
                s.phase = i2cm_pkg::PH_START2;
            end
            i2cm_pkg::PH_START2: begin
                s.sda   = 1'b0;
                s.phase = i2cm_pkg::PH_START3;
            end
            i2cm_pkg::PH_START3: begin
                s.scl     = 1'b0;
                s.shift   = i2cm_pkg::byte_to_send(i_dev_addr, s.held_addr,
                                                   s.held_val, s.byte_num);
                s.bit_num = i2cm_pkg::BIT_MSB;
                s.phase   = i2cm_pkg::PH_WB_SDA;
            end
            i2cm_pkg::PH_WB_SDA: begin
                s.sda   = s.shift[s.bit_num];
                s.phase = i2cm_pkg::PH_WB_SCLH;
            end
            i2cm_pkg::PH_WB_SCLH: begin
                s.scl   = 1'b1;
                s.phase = i2cm_pkg::PH_WB_SCLL;
            end
            i2cm_pkg::PH_WB_SCLL: begin
                s.scl = 1'b0;
                if (s.bit_num == i2cm_pkg::BIT_LSB) begin
                    s.phase = i2cm_pkg::PH_WA_SDA;
                end else begin
                    s.bit_num = s.bit_num - 3'd1;
                    s.phase   = i2cm_pkg::PH_WB_SDA;
                end
            end
            i2cm_pkg::PH_WA_SDA: begin
                s.sda   = 1'b1;
                s.phase = i2cm_pkg::PH_WA_SCLH;
            end
            i2cm_pkg::PH_WA_SCLH: begin
                s.scl = 1'b1;
                if (i_tick.sda_in) begin
                    s.all_acked = 1'b0;
                end
                s.phase = i2cm_pkg::PH_WA_SCLL;
            end
            i2cm_pkg::PH_WA_SCLL: begin
                s.scl = 1'b0;
                if (!s.all_acked) begin
                    s.phase = i2cm_pkg::PH_SP_SDAL;
                end else begin
                    unique case (s.byte_num)
                        i2cm_pkg::BN_DEV_W, i2cm_pkg::BN_REG_LO,
                        i2cm_pkg::BN_DAT_LO: begin
                            s.byte_num = s.byte_num + 3'd1;
                            s.shift    = i2cm_pkg::byte_to_send(i_dev_addr,
                                             s.held_addr, s.held_val, s.byte_num);
                            s.bit_num  = i2cm_pkg::BIT_MSB;
                            s.phase    = i2cm_pkg::PH_WB_SDA;
                        end
                        i2cm_pkg::BN_REG_HI: begin
                            s.bit_num = i2cm_pkg::BIT_MSB;
                            if (s.is_read) begin
                                // repeated start, then read address
                                s.byte_num = i2cm_pkg::BN_DEV_R;
                                s.phase    = i2cm_pkg::PH_START0;
                            end else begin
                                s.byte_num = i2cm_pkg::BN_DAT_LO;
                                s.shift    = i2cm_pkg::byte_to_send(i_dev_addr,
                                                 s.held_addr, s.held_val,
                                                 i2cm_pkg::BN_DAT_LO);
                                s.phase    = i2cm_pkg::PH_WB_SDA;
                            end
                        end
                        i2cm_pkg::BN_DEV_R: begin
                            s.byte_num = i2cm_pkg::BN_RD_LO;
                            s.shift    = '0;
                            s.bit_num  = i2cm_pkg::BIT_MSB;
                            s.phase    = i2cm_pkg::PH_RB_SET;
                        end
                        default: s.phase = i2cm_pkg::PH_SP_SDAL;
                    endcase
                end
            end
            i2cm_pkg::PH_RB_SET: begin
                s.sda   = 1'b1;
                s.phase = i2cm_pkg::PH_RB_SCLH;
            end
            i2cm_pkg::PH_RB_SCLH: begin
                s.scl                = 1'b1;
                s.shift[s.bit_num]   = s.shift[s.bit_num] | i_tick.sda_in;
                s.phase              = i2cm_pkg::PH_RB_SCLL;
            end
            i2cm_pkg::PH_RB_SCLL: begin
                s.scl = 1'b0;
                if (s.bit_num == i2cm_pkg::BIT_LSB) begin
                    s.phase = i2cm_pkg::PH_RA_SDA;
                end else begin
                    s.bit_num = s.bit_num - 3'd1;
                    s.phase   = i2cm_pkg::PH_RB_SCLH;
                end
            end
            i2cm_pkg::PH_RA_SDA: begin
                // ACK the low byte, NACK the high byte
                s.sda   = (s.byte_num == i2cm_pkg::BN_RD_LO) ? 1'b0 : 1'b1;
                s.phase = i2cm_pkg::PH_RA_SCLH;
            end
            i2cm_pkg::PH_RA_SCLH: begin
                s.scl   = 1'b1;
                s.phase = i2cm_pkg::PH_RA_SCLL;
            end
            i2cm_pkg::PH_RA_SCLL: begin
                s.scl   = 1'b0;
                s.phase = i2cm_pkg::PH_RA_REL;
            end
            i2cm_pkg::PH_RA_REL: begin
                s.sda = 1'b1;
                if (s.byte_num == i2cm_pkg::BN_RD_LO) begin
                    s.low_store = s.shift;
                    s.byte_num  = i2cm_pkg::BN_RD_HI;
                    s.shift     = '0;
                    s.bit_num   = i2cm_pkg::BIT_MSB;
                    s.phase     = i2cm_pkg::PH_RB_SET;
                end else begin
                    s.read_result = {s.shift, s.low_store};
                    s.phase       = i2cm_pkg::PH_SP_SDAL;
                end
            end
            i2cm_pkg::PH_SP_SDAL: begin
                s.sda   = 1'b0;
                s.phase = i2cm_pkg::PH_SP_SCLH;
            end
            i2cm_pkg::PH_SP_SCLH: begin
                s.scl   = 1'b1;
                s.phase = i2cm_pkg::PH_SP_SDAH;
            end
            i2cm_pkg::PH_SP_SDAH: begin
                s.sda        = 1'b1;
                o_flags.done = 1'b1;
                o_flags.ok   = s.all_acked;
                s.phase      = i2cm_pkg::PH_IDLE;
            end
            default: s.phase = i2cm_pkg::PH_IDLE;
        endcase
        o_state = s;
    end

endmodule

[rtl/core/i2c_reg16_bitbang_master.sv]
// ---------------------------------------------------------------------------
// i2c_reg16_bitbang_master
// Open-drain I2C master doing one 16-bit register write or read per command,
// one bus line change per tick beat.
// ---------------------------------------------------------------------------
// Path: an accepted tick beat reaches its result beat on the output through
//   the input register, then the result register.
// Throughput: 1 tick beat per cycle while the output is not stalled; the step
//   logic and the sequencer state update both complete between the two registers.
// Reset: i_rst_n synchronous, active low. Sequencer goes idle, both lines
//   released, read value cleared, device address back to 86.
module i2c_reg16_bitbang_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick beats in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [15:0] register_address,
                                        // [31:16] write_value, [32] sda_in,
                                        // [39:33] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    // result beats out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] scl_release, [1] sda_release,
                                        // [2] busy_res, [3] done_res,
                                        // [4] success, [20:5] read_value,
                                        // [23:21] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // input register: one tick beat waiting for its step
    logic                        r_in_valid;
    i2cm_pkg::t_tick             r_in;

    // result register
    logic                        r_out_valid;
    logic [23:0]                 r_out_data;

    // sequencer state and config
    i2cm_pkg::t_state            r_state;
    i2cm_pkg::t_state            n_state;
    i2cm_pkg::t_flags            w_flags;
    logic [i2cm_pkg::DEV_W-1:0]  r_dev_addr;

    logic                        w_step;
    logic                        w_cfg_wr;

    // a step happens whenever a tick is held and the result slot frees up
    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    // ---- APB ----
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == i2cm_pkg::REG_DEVICE_ADDR);
    assign prdata   = (paddr[2] == i2cm_pkg::REG_DEVICE_ADDR) ?
                      {25'd0, r_dev_addr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= i2cm_pkg::DEV_ADDR_RST;
        end else if (w_cfg_wr) begin
            r_dev_addr <= pwdata[6:0];
        end
    end

    // ---- input register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.action   <= s_axis_tuser;
            r_in.reg_addr <= s_axis_tdata[15:0];
            r_in.wr_val   <= s_axis_tdata[31:16];
            r_in.sda_in   <= s_axis_tdata[32];
        end
    end

    // ---- bus step ----
    i2cm_step u_step (
        .i_state    (r_state),
        .i_tick     (r_in),
        .i_dev_addr (r_dev_addr),
        .o_state    (n_state),
        .o_flags    (w_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= i2cm_pkg::PH_IDLE;
            r_state.byte_num    <= i2cm_pkg::BN_DEV_W;
            r_state.bit_num     <= i2cm_pkg::BIT_MSB;
            r_state.shift       <= '0;
            r_state.low_store   <= '0;
            r_state.read_result <= '0;
            r_state.held_addr   <= '0;
            r_state.held_val    <= '0;
            r_state.is_read     <= 1'b0;
            r_state.all_acked   <= 1'b1;
            r_state.scl         <= 1'b1;
            r_state.sda         <= 1'b1;
        end else if (w_step) begin
            r_state <= n_state;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= {3'd0, n_state.read_result, w_flags.ok, w_flags.done,
                           (n_state.phase != i2cm_pkg::PH_IDLE),
                           n_state.sda, n_state.scl};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // a stop completes into idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_flags.done) |=> (r_state.phase == i2cm_pkg::PH_IDLE))
        else $error("done without returning to idle");

    // success is only reported with done
    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_flags.ok) |-> w_flags.done)
        else $error("success flagged outside a stop");

    // a held tick is never dropped while the result slot is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_step) |=> r_in_valid)
        else $error("tick beat lost");

    // the bus is released on both lines whenever the sequencer is idle
    a_idle_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == i2cm_pkg::PH_IDLE) |-> (r_state.scl && r_state.sda))
        else $error("line held while idle");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the 16-bit register I2C master. Tick beats go in on
// the input stream, and a small slave model picks each beat's SDA sample from
// the bus phase that the built-in predictor expects. The predictor works out
// the line levels and flags of every result beat, and each result beat that
// comes out is checked against the oldest expected one.
// ---------------------------------------------------------------------------
module tb;

    // action code with no meaning, treated as a plain tick by the block
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // byte address of the device address register
    localparam logic [2:0] ADDR_DEVICE = {i2cm_pkg::REG_DEVICE_ADDR, 2'b00};
    // input register plus result register
    localparam int LATENCY = 2;
    // slave never NACKs
    localparam int NO_NACK = -1;
    localparam int RANDOM_TICKS = 80;

    // one result beat, unpacked from m_axis_tdata
    typedef struct packed {
        logic                        scl;
        logic                        sda;
        logic                        busy;
        logic                        done;
        logic                        ok;
        logic [i2cm_pkg::WORD_W-1:0] rd_val;
    } t_line_res;

    // ---------------------------------------------------------------------
    // clock, reset and DUT
    // ---------------------------------------------------------------------
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // [15:0] register_address,
                                       // [31:16] write_value, [32] sda_in,
                                       // [39:33] zero
    logic [1:0]  s_axis_tuser  = i2cm_pkg::ACT_TICK; // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [0] scl_release, [1] sda_release,
                                       // [2] busy_res, [3] done_res,
                                       // [4] success, [20:5] read_value,
                                       // [23:21] zero
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    always #5 i_clk = ~i_clk;

    i2c_reg16_bitbang_master DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ---------------------------------------------------------------------
    // bench state
    // ---------------------------------------------------------------------
    t_line_res                   line_q[$];      // expected result beats, oldest first
    int                          bad_beats    = 0;
    int                          ticks_sent   = 0;
    int                          tx_gap_max   = 7;
    int                          rx_stall_max = 7;
    int                          rx_hold      = 0;  // long output stall, in cycles
    int                          rx_wait      = 0;  // per-beat output stall
    logic [i2cm_pkg::WORD_W-1:0] slave_rd_word = '0; // what the slave returns on reads
    t_line_res                   got_res, want_res;

    // ---------------------------------------------------------------------
    // bus sequencer predictor: one line change per tick
    // ---------------------------------------------------------------------
    logic [i2cm_pkg::DEV_W-1:0]  dev_addr_q;
    i2cm_pkg::t_phase            bus_phase;
    logic [i2cm_pkg::IDX_W-1:0]  byte_slot;
    logic [i2cm_pkg::IDX_W-1:0]  bit_idx;
    logic [i2cm_pkg::BYTE_W-1:0] shift_reg;
    logic [i2cm_pkg::BYTE_W-1:0] rd_low;
    logic [i2cm_pkg::WORD_W-1:0] rd_word;
    logic [i2cm_pkg::WORD_W-1:0] cmd_addr;
    logic [i2cm_pkg::WORD_W-1:0] cmd_val;
    logic                        cmd_is_read;
    logic                        all_ack;
    logic                        scl_lvl;
    logic                        sda_lvl;

    initial begin
        dev_addr_q  = i2cm_pkg::DEV_ADDR_RST;
        bus_phase   = i2cm_pkg::PH_IDLE;
        byte_slot   = i2cm_pkg::BN_DEV_W;
        bit_idx     = i2cm_pkg::BIT_MSB;
        shift_reg   = '0;
        rd_low      = '0;
        rd_word     = '0;
        cmd_addr    = '0;
        cmd_val     = '0;
        cmd_is_read = 1'b0;
        all_ack     = 1'b1;
        scl_lvl     = 1'b1;
        sda_lvl     = 1'b1;
    end

    // byte shifted out in a given slot; device address is taken live
    function automatic logic [i2cm_pkg::BYTE_W-1:0] byte_for_slot(
        input logic [i2cm_pkg::IDX_W-1:0] slot
    );
        case (slot)
            i2cm_pkg::BN_DEV_W:  return {dev_addr_q, 1'b0};
            i2cm_pkg::BN_REG_LO: return cmd_addr[7:0];
            i2cm_pkg::BN_REG_HI: return cmd_addr[15:8];
            i2cm_pkg::BN_DAT_LO: return cmd_val[7:0];
            i2cm_pkg::BN_DAT_HI: return cmd_val[15:8];
            default:             return {dev_addr_q, 1'b1};
        endcase
    endfunction

    task automatic load_slot(input logic [i2cm_pkg::IDX_W-1:0] slot);
        byte_slot = slot;
        shift_reg = byte_for_slot(slot);
        bit_idx   = i2cm_pkg::BIT_MSB;
        bus_phase = i2cm_pkg::PH_WB_SDA;
    endtask

    task automatic start_rd_byte(input logic [i2cm_pkg::IDX_W-1:0] slot);
        byte_slot = slot;
        shift_reg = '0;
        bit_idx   = i2cm_pkg::BIT_MSB;
        bus_phase = i2cm_pkg::PH_RB_SET;
    endtask

    task automatic step_bus(input logic [1:0] act,
                            input logic [i2cm_pkg::WORD_W-1:0] ra,
                            input logic [i2cm_pkg::WORD_W-1:0] wv, input logic sd,
                            output t_line_res r);
        logic done_p;
        logic ok_p;
        done_p = 1'b0;
        ok_p   = 1'b0;
        // a command is taken only when idle and starts on the same tick
        if (bus_phase == i2cm_pkg::PH_IDLE &&
            (act == i2cm_pkg::ACT_WRITE || act == i2cm_pkg::ACT_READ)) begin
            cmd_addr    = ra;
            cmd_val     = wv;
            cmd_is_read = (act == i2cm_pkg::ACT_READ);
            all_ack     = 1'b1;
            byte_slot   = i2cm_pkg::BN_DEV_W;
            bit_idx     = i2cm_pkg::BIT_MSB;
            bus_phase   = i2cm_pkg::PH_START0;
        end
        case (bus_phase)
            i2cm_pkg::PH_START0: begin
                sda_lvl   = 1'b1;
                bus_phase = i2cm_pkg::PH_START1;
            end
            i2cm_pkg::PH_START1: begin
                scl_lvl   = 1'b1;
                bus_phase = i2cm_pkg::PH_START2;
            end
            i2cm_pkg::PH_START2: begin
                sda_lvl   = 1'b0;
                bus_phase = i2cm_pkg::PH_START3;
            end
            i2cm_pkg::PH_START3: begin
                scl_lvl = 1'b0;
                load_slot(byte_slot);
            end
            i2cm_pkg::PH_WB_SDA: begin
                sda_lvl   = shift_reg[bit_idx];
                bus_phase = i2cm_pkg::PH_WB_SCLH;
            end
            i2cm_pkg::PH_WB_SCLH: begin
                scl_lvl   = 1'b1;
                bus_phase = i2cm_pkg::PH_WB_SCLL;
            end
            i2cm_pkg::PH_WB_SCLL: begin
                scl_lvl = 1'b0;
                if (bit_idx == i2cm_pkg::BIT_LSB) begin
                    bus_phase = i2cm_pkg::PH_WA_SDA;
                end else begin
                    bit_idx   = bit_idx - 3'd1;
                    bus_phase = i2cm_pkg::PH_WB_SDA;
                end
            end
            i2cm_pkg::PH_WA_SDA: begin
                sda_lvl   = 1'b1;
                bus_phase = i2cm_pkg::PH_WA_SCLH;
            end
            i2cm_pkg::PH_WA_SCLH: begin
                scl_lvl = 1'b1;
                if (sd) all_ack = 1'b0;
                bus_phase = i2cm_pkg::PH_WA_SCLL;
            end
            i2cm_pkg::PH_WA_SCLL: begin
                scl_lvl = 1'b0;
                if (!all_ack) begin
                    bus_phase = i2cm_pkg::PH_SP_SDAL;
                end else begin
                    case (byte_slot)
                        i2cm_pkg::BN_DEV_W, i2cm_pkg::BN_REG_LO,
                        i2cm_pkg::BN_DAT_LO: load_slot(byte_slot + 3'd1);
                        i2cm_pkg::BN_REG_HI: begin
                            if (cmd_is_read) begin
                                // repeated start, then the read address
                                byte_slot = i2cm_pkg::BN_DEV_R;
                                bit_idx   = i2cm_pkg::BIT_MSB;
                                bus_phase = i2cm_pkg::PH_START0;
                            end else begin
                                load_slot(i2cm_pkg::BN_DAT_LO);
                            end
                        end
                        i2cm_pkg::BN_DEV_R: start_rd_byte(i2cm_pkg::BN_RD_LO);
                        default:            bus_phase = i2cm_pkg::PH_SP_SDAL;
                    endcase
                end
            end
            i2cm_pkg::PH_RB_SET: begin
                sda_lvl   = 1'b1;
                bus_phase = i2cm_pkg::PH_RB_SCLH;
            end
            i2cm_pkg::PH_RB_SCLH: begin
                scl_lvl            = 1'b1;
                shift_reg[bit_idx] = shift_reg[bit_idx] | sd;
                bus_phase          = i2cm_pkg::PH_RB_SCLL;
            end
            i2cm_pkg::PH_RB_SCLL: begin
                scl_lvl = 1'b0;
                if (bit_idx == i2cm_pkg::BIT_LSB) begin
                    bus_phase = i2cm_pkg::PH_RA_SDA;
                end else begin
                    bit_idx   = bit_idx - 3'd1;
                    bus_phase = i2cm_pkg::PH_RB_SCLH;
                end
            end
            i2cm_pkg::PH_RA_SDA: begin
                // ACK after the low byte, NACK after the high byte
                sda_lvl   = (byte_slot == i2cm_pkg::BN_RD_LO) ? 1'b0 : 1'b1;
                bus_phase = i2cm_pkg::PH_RA_SCLH;
            end
            i2cm_pkg::PH_RA_SCLH: begin
                scl_lvl   = 1'b1;
                bus_phase = i2cm_pkg::PH_RA_SCLL;
            end
            i2cm_pkg::PH_RA_SCLL: begin
                scl_lvl   = 1'b0;
                bus_phase = i2cm_pkg::PH_RA_REL;
            end
            i2cm_pkg::PH_RA_REL: begin
                sda_lvl = 1'b1;
                if (byte_slot == i2cm_pkg::BN_RD_LO) begin
                    rd_low = shift_reg;
                    start_rd_byte(i2cm_pkg::BN_RD_HI);
                end else begin
                    rd_word   = {shift_reg, rd_low};
                    bus_phase = i2cm_pkg::PH_SP_SDAL;
                end
            end
            i2cm_pkg::PH_SP_SDAL: begin
                sda_lvl   = 1'b0;
                bus_phase = i2cm_pkg::PH_SP_SCLH;
            end
            i2cm_pkg::PH_SP_SCLH: begin
                scl_lvl   = 1'b1;
                bus_phase = i2cm_pkg::PH_SP_SDAH;
            end
            i2cm_pkg::PH_SP_SDAH: begin
                sda_lvl   = 1'b1;
                done_p    = 1'b1;
                ok_p      = all_ack;
                bus_phase = i2cm_pkg::PH_IDLE;
            end
            default: ;
        endcase
        r.scl    = scl_lvl;
        r.sda    = sda_lvl;
        r.busy   = (bus_phase != i2cm_pkg::PH_IDLE);
        r.done   = done_p;
        r.ok     = ok_p;
        r.rd_val = rd_word;
    endtask

    // slave side of SDA for the coming tick: ACK or NACK in the ack slot,
    // read data bits while the master samples, noise elsewhere
    function automatic logic slave_sda(input int nack_slot);
        if (bus_phase == i2cm_pkg::PH_WA_SCLH) return (int'(byte_slot) == nack_slot);
        if (bus_phase == i2cm_pkg::PH_RB_SCLH) begin
            if (byte_slot == i2cm_pkg::BN_RD_LO) return slave_rd_word[bit_idx];
            return slave_rd_word[i2cm_pkg::BYTE_W + int'(bit_idx)];
        end
        return 1'($urandom);
    endfunction

    // ---------------------------------------------------------------------
    // input side: one tick beat per call, called and returning at a falling
    // edge; tvalid stays high into the next call unless it draws a gap
    // ---------------------------------------------------------------------
    task automatic send_tick(input logic [1:0] act,
                             input logic [i2cm_pkg::WORD_W-1:0] ra,
                             input logic [i2cm_pkg::WORD_W-1:0] wv, input logic sd);
        int        gap;
        t_line_res r;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {7'd0, sd, wv, ra};
        do @(posedge i_clk); while (!s_axis_tready);
        step_bus(act, ra, wv, sd, r);
        line_q.push_back(r);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_input;
        s_axis_tvalid <= 1'b0;
    endtask

    // beats that carry no command, or the unused action code
    task automatic quiet_ticks(input int n);
        repeat (n) send_tick($urandom_range(0, 1) ? i2cm_pkg::ACT_TICK : ACT_UNUSED,
                             16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // tick until the predictor says the bus is idle again; busy beats carry
    // random actions, which the block must ignore
    task automatic finish_cmd(input int nack_slot);
        while (bus_phase != i2cm_pkg::PH_IDLE)
            send_tick(2'($urandom), 16'($urandom), 16'($urandom), slave_sda(nack_slot));
    endtask

    task automatic run_cmd(input logic [1:0] act, input logic [i2cm_pkg::WORD_W-1:0] ra,
                           input logic [i2cm_pkg::WORD_W-1:0] wv, input int nack_slot);
        send_tick(act, ra, wv, 1'($urandom));
        finish_cmd(nack_slot);
    endtask

    // sender pause: nothing more goes in until every result beat is back
    task automatic wait_drain;
        while (line_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // output side: ready is driven at the falling edge, beats are checked at
    // the rising edge
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold--;
        end else if (rx_wait > 0) begin
            m_axis_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic flag_beat(input string what, input t_line_res want,
                             input t_line_res got);
        bad_beats++;
        if (bad_beats <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("  exp scl=%0b sda=%0b busy=%0b done=%0b ok=%0b rd=%h",
                     want.scl, want.sda, want.busy, want.done, want.ok, want.rd_val);
            $display("  got scl=%0b sda=%0b busy=%0b done=%0b ok=%0b rd=%h",
                     got.scl, got.sda, got.busy, got.done, got.ok, got.rd_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_wait        = $urandom_range(0, rx_stall_max);
            got_res.scl    = m_axis_tdata[0];
            got_res.sda    = m_axis_tdata[1];
            got_res.busy   = m_axis_tdata[2];
            got_res.done   = m_axis_tdata[3];
            got_res.ok     = m_axis_tdata[4];
            got_res.rd_val = m_axis_tdata[20:5];
            if (line_q.size() == 0) begin
                flag_beat("beat with nothing expected", '0, got_res);
            end else begin
                want_res = line_q.pop_front();
                if (got_res.scl !== want_res.scl || got_res.sda !== want_res.sda ||
                    got_res.busy !== want_res.busy || got_res.done !== want_res.done ||
                    got_res.ok !== want_res.ok || got_res.rd_val !== want_res.rd_val)
                    flag_beat("result mismatch", want_res, got_res);
            end
        end
    end

    // ---------------------------------------------------------------------
    // configuration port; register written in the access cycle
    // ---------------------------------------------------------------------
    task automatic cfg_write(input logic [i2cm_pkg::DEV_W-1:0] dev);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DEVICE;
        pwdata  <= {25'($urandom), dev};   // upper bits must be dropped
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        dev_addr_q = dev;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check;
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_DEVICE;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {25'd0, dev_addr_q}) begin
            bad_beats++;
            if (bad_beats <= 10)
                $display("%0t: device address readback: exp %h got %h",
                         $realtime, {25'd0, dev_addr_q}, rd);
        end
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // reset value, field extremes on plain ticks, unused action, and
    // commands arriving while a transfer is already running
    task automatic test_quiet_ticks;
        cfg_check();
        send_tick(i2cm_pkg::ACT_TICK,  16'h0000, 16'h0000, 1'b0);
        send_tick(i2cm_pkg::ACT_TICK,  16'hFFFF, 16'hFFFF, 1'b1);
        send_tick(ACT_UNUSED,          16'hFFFF, 16'hFFFF, 1'b1);
        send_tick(ACT_UNUSED,          16'h0000, 16'h0000, 1'b0);
        send_tick(i2cm_pkg::ACT_WRITE, 16'hFFFF, 16'hFFFF, 1'b1);
        send_tick(i2cm_pkg::ACT_READ,  16'h0000, 16'h0000, 1'b0);
        send_tick(i2cm_pkg::ACT_WRITE, 16'h5A5A, 16'hA5A5, 1'b1);
        send_tick(ACT_UNUSED,          16'hFFFF, 16'h0000, 1'b0);
        finish_cmd(NO_NACK);
        quiet_ticks(4);
    endtask

    // all-ones register address, all-zeros data
    task automatic test_full_write;
        run_cmd(i2cm_pkg::ACT_WRITE, 16'hFFFF, 16'h0000, NO_NACK);
    endtask

    // all-ones read data; all-zeros data follows in the device address test
    task automatic test_full_read;
        slave_rd_word = 16'hFFFF;
        run_cmd(i2cm_pkg::ACT_READ, 16'h0000, 16'($urandom), NO_NACK);
    endtask

    // NACK on each byte of a write, and on the read address of a read;
    // a failed read keeps the old value
    task automatic test_nack_per_byte;
        for (int s = int'(i2cm_pkg::BN_DEV_W); s <= int'(i2cm_pkg::BN_DAT_HI); s++)
            run_cmd(i2cm_pkg::ACT_WRITE, 16'($urandom), 16'($urandom), s);
        slave_rd_word = 16'($urandom);
        run_cmd(i2cm_pkg::ACT_READ, 16'($urandom), 16'($urandom),
                int'(i2cm_pkg::BN_DEV_R));
    endtask

    // device address extremes, then back to the reset value; each read sends
    // both the write and the read form of the address
    task automatic test_device_address;
        logic [i2cm_pkg::DEV_W-1:0] devs[3];
        devs[0] = '0;
        devs[1] = '1;
        devs[2] = i2cm_pkg::DEV_ADDR_RST;
        foreach (devs[i]) begin
            idle_input();
            wait_drain();
            cfg_write(devs[i]);
            cfg_check();
            slave_rd_word = (i == 0) ? 16'h0000 : 16'($urandom);
            run_cmd(i2cm_pkg::ACT_READ, 16'($urandom), 16'($urandom), NO_NACK);
        end
    endtask

    // long output hold while the input keeps streaming, so the block backs
    // up and stalls its input; then a pause until everything is back
    task automatic test_output_stall;
        tx_gap_max   = 0;
        rx_stall_max = 0;
        rx_hold      = 60;
        quiet_ticks(24);
        idle_input();
        wait_drain();
        tx_gap_max   = 7;
        rx_stall_max = 7;
    endtask

    // mostly well-formed transfers with random content, some NACKs,
    // idle ticks in between and idling switched on and off per transfer
    task automatic test_random_traffic;
        int         stop_at;
        int         nack_slot;
        logic [1:0] act;
        stop_at = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < stop_at) begin
            tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 7;
            rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            quiet_ticks($urandom_range(0, 5));
            act           = $urandom_range(0, 1) ? i2cm_pkg::ACT_WRITE : i2cm_pkg::ACT_READ;
            slave_rd_word = 16'($urandom);
            nack_slot     = NO_NACK;
            if ($urandom_range(0, 3) == 0) begin
                nack_slot = $urandom_range(int'(i2cm_pkg::BN_DEV_W),
                                           int'(i2cm_pkg::BN_DAT_HI));
                if (act == i2cm_pkg::ACT_READ && nack_slot > int'(i2cm_pkg::BN_REG_HI))
                    nack_slot = int'(i2cm_pkg::BN_DEV_R);
            end
            run_cmd(act, 16'($urandom), 16'($urandom), nack_slot);
        end
        tx_gap_max   = 7;
        rx_stall_max = 7;
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_quiet_ticks();
        test_full_write();
        test_full_read();
        test_nack_per_byte();
        test_device_address();
        test_output_stall();
        test_random_traffic();

        idle_input();
        wait_drain();
        repeat (8) @(posedge i_clk);
        if (bad_beats == 0 && line_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // hang guard, far above the slowest correct run
    initial begin
        #(5_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
